// File: rtl/core/hlcd_pkg.sv
// Shared types, constants and functions for the header/length/CRC deframer.
// No dependencies; the modules of the block import this package.
package hlcd_pkg;

  localparam int HLCD_MAX_HDR = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam logic [2:0] REG_HEADER_PATTERN = 3'd0;
  localparam logic [2:0] REG_HEADER_LENGTH  = 3'd1;
  localparam logic [2:0] REG_LENGTH_OFFSET  = 3'd2;
  localparam logic [2:0] REG_LENGTH_SIZE    = 3'd3;
  localparam logic [2:0] REG_CRC_ENABLE     = 3'd4;

  localparam logic RESULT_PAYLOAD   = 1'b0;
  localparam logic RESULT_FRAME_END = 1'b1;

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_OFFSET  = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRCH    = 6'b010000,
    PH_CRCL    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [31:0] header_pattern;
    logic [2:0]  header_length;
    logic [3:0]  length_field_offset;
    logic [1:0]  length_field_size;
    logic        crc_check_enable;
  } cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  out_byte;
    logic [15:0] frame_payload_length;
    logic        frame_status;
    logic        frame_last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } res_push_t;

  // What entering a stage does once empty stages are skipped
  typedef struct packed {
    phase_t phase;
    logic   hunt_reset;
    logic   fc_clr;
    logic   plr_clr;
  } enter_t;

  function automatic logic [15:0] hlcd_crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] hlcd_hdr_byte(logic [31:0] pattern, logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = pattern[31:24];
      2'd1:    r = pattern[23:16];
      2'd2:    r = pattern[15:8];
      default: r = pattern[7:0];
    endcase
    return r;
  endfunction

  // Enter stage s and fall through every stage that has nothing to read.
  function automatic enter_t hlcd_enter(phase_t s, cfg_t c, logic [2:0] hl,
                                        logic plr_zero);
    enter_t e;
    logic   off_nz;
    logic   ls_nz;
    logic   all_empty;
    logic   at_hunt;
    logic   at_off;
    logic   at_len;
    logic   at_pay;
    logic   at_crc;
    off_nz    = (c.length_field_offset != 4'd0);
    ls_nz     = (c.length_field_size != 2'd0);
    all_empty = !off_nz && !ls_nz && !c.crc_check_enable;
    at_hunt   = (s == PH_HUNT);
    at_off    = (s == PH_OFFSET);
    at_len    = (s == PH_LEN);
    at_pay    = (s == PH_PAYLOAD);
    at_crc    = (s == PH_CRCH);
    e.phase      = PH_HUNT;
    e.hunt_reset = 1'b0;
    e.fc_clr     = 1'b0;
    e.plr_clr    = 1'b0;
    if (at_hunt) begin
      e.hunt_reset = 1'b1;
      if (hl != 3'd0 || all_empty) e.phase = PH_HUNT;
      else at_off = 1'b1;
    end
    if (at_off) begin
      e.fc_clr = 1'b1;
      if (off_nz) e.phase = PH_OFFSET;
      else at_len = 1'b1;
    end
    if (at_len) begin
      e.fc_clr  = 1'b1;
      e.plr_clr = 1'b1;
      if (ls_nz) e.phase = PH_LEN;
      else at_pay = 1'b1;
    end
    if (at_pay) begin
      if (!e.plr_clr && !plr_zero) e.phase = PH_PAYLOAD;
      else at_crc = 1'b1;
    end
    if (at_crc) begin
      if (c.crc_check_enable) begin
        e.phase = PH_CRCH;
      end else begin
        // back to the hunt; with no header the next frame starts at once
        e.hunt_reset = 1'b1;
        if (hl != 3'd0 || all_empty) begin
          e.phase = PH_HUNT;
        end else if (off_nz) begin
          e.fc_clr = 1'b1;
          e.phase  = PH_OFFSET;
        end else if (ls_nz) begin
          e.fc_clr  = 1'b1;
          e.plr_clr = 1'b1;
          e.phase   = PH_LEN;
        end else begin
          e.phase = PH_HUNT;
        end
      end
    end
    return e;
  endfunction

endpackage

// File: rtl/core/hlcd_if.sv
// Channel interfaces of the deframer: byte stream, result stream, config writes.
// Depends on nothing; payload names follow the block's field list.
interface hlcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hlcd_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  out_byte;
  logic [15:0] frame_payload_length;
  logic        frame_status;
  logic        frame_last;
  modport source (output valid, output result_kind, output out_byte,
                  output frame_payload_length, output frame_status,
                  output frame_last, input ready);
  modport sink   (input valid, input result_kind, input out_byte,
                  input frame_payload_length, input frame_status,
                  input frame_last, output ready);
endinterface

interface hlcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/hlcd_cfg_regs.sv
// Configuration register file of the deframer and its restart strobe.
// Depends on hlcd_pkg and hlcd_cfg_if.
module hlcd_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  hlcd_cfg_if.sink      cfg,
  output hlcd_pkg::cfg_t regs,
  output logic          restart
);
  import hlcd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.header_pattern      <= 32'd0;
      regs.header_length       <= 3'd2;
      regs.length_field_offset <= 4'd0;
      regs.length_field_size   <= 2'd1;
      regs.crc_check_enable    <= 1'b1;
      restart                  <= 1'b0;
    end else begin
      // unmapped indexes change nothing and leave the frame alone
      restart <= cfg.valid && (cfg.index inside {REG_HEADER_PATTERN, REG_HEADER_LENGTH,
                                                 REG_LENGTH_OFFSET, REG_LENGTH_SIZE,
                                                 REG_CRC_ENABLE});
      if (cfg.valid) begin
        case (cfg.index)
          REG_HEADER_PATTERN: regs.header_pattern      <= cfg.data;
          REG_HEADER_LENGTH:  regs.header_length       <= cfg.data[2:0];
          REG_LENGTH_OFFSET:  regs.length_field_offset <= cfg.data[3:0];
          REG_LENGTH_SIZE:    regs.length_field_size   <= cfg.data[1:0];
          REG_CRC_ENABLE:     regs.crc_check_enable    <= cfg.data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/hlcd_parser.sv
// Input register, frame state and running CRC: one byte is parsed per cycle while the output has room.
// Depends on hlcd_pkg and hlcd_byte_if.
module hlcd_parser #(
  parameter int MAX_HEADER_BYTES = hlcd_pkg::HLCD_MAX_HDR
) (
  input  logic              clk,
  input  logic              rst,
  hlcd_byte_if.sink         stream,
  input  hlcd_pkg::cfg_t    cfg,
  input  logic              restart,
  input  logic              room,
  output logic              busy,
  output hlcd_pkg::res_push_t push
);
  import hlcd_pkg::*;

  localparam logic [2:0] HL_CAP = (MAX_HEADER_BYTES > 4) ? 3'd4 : 3'(MAX_HEADER_BYTES);

  logic        in_q_valid;
  logic [7:0]  in_q_byte;
  logic        advance;

  phase_t      phase, phase_next;
  logic [2:0]  matched, matched_next;
  logic [3:0]  fc, fc_next;
  logic [15:0] plr, plr_next;
  logic [15:0] rem, rem_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crch, crch_next;

  logic [2:0]  hl;
  logic [1:0]  ls_sat;
  logic [3:0]  fc_inc;
  logic        do_enter;
  phase_t      enter_from;
  enter_t      ent;

  assign hl     = (cfg.header_length > HL_CAP) ? HL_CAP : cfg.header_length;
  assign ls_sat = (cfg.length_field_size == 2'd3) ? 2'd2 : cfg.length_field_size;
  assign fc_inc = fc + 4'd1;

  assign advance      = in_q_valid && room;
  assign stream.ready = !in_q_valid || room;
  assign busy         = in_q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (stream.ready) begin
      in_q_valid <= stream.valid;
    end
    if (stream.ready) begin
      in_q_byte <= stream.in_byte;
    end
  end

  always_comb begin
    phase_next   = phase;
    matched_next = matched;
    fc_next      = fc;
    plr_next     = plr;
    rem_next     = rem;
    crc_next     = crc;
    crch_next    = crch;
    push         = '0;
    do_enter     = 1'b0;
    enter_from   = PH_HUNT;
    if (restart) begin
      do_enter = 1'b1;
    end else if (advance) begin
      case (phase)
        PH_HUNT: begin
          if (hl != 3'd0) begin
            if (in_q_byte == hlcd_hdr_byte(cfg.header_pattern, matched[1:0])) begin
              crc_next     = hlcd_crc_byte(crc, in_q_byte);
              matched_next = matched + 3'd1;
              if (matched_next >= hl) begin
                do_enter   = 1'b1;
                enter_from = PH_OFFSET;
              end
            end else if (in_q_byte == hlcd_hdr_byte(cfg.header_pattern, 2'd0)) begin
              // mismatch, but the byte opens a new header
              crc_next     = hlcd_crc_byte(CRC_INIT, in_q_byte);
              matched_next = 3'd1;
              if (hl <= 3'd1) begin
                do_enter   = 1'b1;
                enter_from = PH_OFFSET;
              end
            end else begin
              crc_next     = CRC_INIT;
              matched_next = 3'd0;
            end
          end
        end
        PH_OFFSET: begin
          crc_next = hlcd_crc_byte(crc, in_q_byte);
          fc_next  = fc_inc;
          if (fc_inc >= cfg.length_field_offset) begin
            do_enter   = 1'b1;
            enter_from = PH_LEN;
          end
        end
        PH_LEN: begin
          crc_next = hlcd_crc_byte(crc, in_q_byte);
          plr_next = {plr[7:0], in_q_byte};
          fc_next  = fc_inc;
          if (fc_inc >= {2'b00, ls_sat}) begin
            do_enter   = 1'b1;
            enter_from = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_next                 = hlcd_crc_byte(crc, in_q_byte);
          push.valid               = 1'b1;
          push.data.result_kind    = RESULT_PAYLOAD;
          push.data.out_byte       = in_q_byte;
          rem_next                 = rem - 16'd1;
          if (rem_next == 16'd0) begin
            do_enter   = 1'b1;
            enter_from = PH_CRCH;
          end
        end
        PH_CRCH: begin
          crch_next  = in_q_byte;
          phase_next = PH_CRCL;
        end
        PH_CRCL: begin
          push.valid                     = 1'b1;
          push.data.result_kind          = RESULT_FRAME_END;
          push.data.frame_payload_length = plr;
          push.data.frame_status         = ({crch, in_q_byte} != crc);
          push.data.frame_last           = 1'b1;
          do_enter                       = 1'b1;
        end
        default: do_enter = 1'b1;
      endcase
    end
    ent = hlcd_enter(enter_from, cfg, hl, plr_next == 16'd0);
    if (do_enter) begin
      phase_next = ent.phase;
      if (ent.hunt_reset) begin
        crc_next     = CRC_INIT;
        matched_next = 3'd0;
      end
      if (ent.fc_clr)  fc_next  = 4'd0;
      if (ent.plr_clr) plr_next = 16'd0;
      if (ent.phase == PH_PAYLOAD) rem_next = plr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      matched <= 3'd0;
      fc      <= 4'd0;
      plr     <= 16'd0;
      rem     <= 16'd0;
      crc     <= CRC_INIT;
      crch    <= 8'd0;
    end else begin
      phase   <= phase_next;
      matched <= matched_next;
      fc      <= fc_next;
      plr     <= plr_next;
      rem     <= rem_next;
      crc     <= crc_next;
      crch    <= crch_next;
    end
  end

endmodule

// File: rtl/core/hlcd_out_skid.sv
// Result register with a skid entry; ready toward the parser is registered.
// Depends on hlcd_pkg and hlcd_result_if.
module hlcd_out_skid (
  input  logic                clk,
  input  logic                rst,
  input  hlcd_pkg::res_push_t push,
  output logic                room,
  hlcd_result_if.source       result
);
  import hlcd_pkg::*;

  logic    out_valid;
  result_t main_q;
  logic    skid_valid;
  result_t skid_q;
  logic    load_main;

  assign load_main = !out_valid || result.ready;
  assign room      = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_main) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push.valid;
      end
    end else if (push.valid) begin
      skid_valid <= 1'b1;
    end
    if (load_main) begin
      main_q <= skid_valid ? skid_q : push.data;
    end else if (push.valid) begin
      skid_q <= push.data;
    end
  end

  assign result.valid                = out_valid;
  assign result.result_kind          = main_q.result_kind;
  assign result.out_byte             = main_q.out_byte;
  assign result.frame_payload_length = main_q.frame_payload_length;
  assign result.frame_status         = main_q.frame_status;
  assign result.frame_last           = main_q.frame_last;

endmodule

// File: rtl/core/header_length_crc_deframer.sv
// Header/length/CRC deframer top level: config registers, parser, result skid.
// Depends on hlcd_pkg, hlcd_if.sv, hlcd_cfg_regs, hlcd_parser, hlcd_out_skid.
//
// Use: bytes of a received stream enter on "stream", one per item. The block
// hunts for the configured header, skips the offset bytes, reads a big-endian
// length and forwards each payload byte as a result item. With CRC checking
// on, the two trailing CRC bytes produce one frame-end item carrying the
// payload length and a status (1 = CRC mismatch; downstream drops the frame).
// Throughput: one byte per cycle while the receiver keeps up. A result reaches
// "result" through the input register, then the result register. The CRC
// update is an eight-step XOR network inside the parser cycle, which sets the
// clock path.
// Config writes on "cfg" are always accepted; a write to a mapped register
// restarts the hunt in the cycle after; write only while the block is idle.
// Reset (rst, synchronous): registers return to header length 2, pattern 0,
// offset 0, one length byte, CRC on; the parser hunts for a header.
// When the receiver stalls, one result waits in the output register and one
// more in a skid entry; after that "stream.ready" drops while a byte is held, until room frees up.
module header_length_crc_deframer #(
  parameter int MAX_HEADER_BYTES = hlcd_pkg::HLCD_MAX_HDR
) (
  input  logic          clk,
  input  logic          rst,
  hlcd_cfg_if.sink      cfg,
  hlcd_byte_if.sink     stream,
  hlcd_result_if.source result
);
  import hlcd_pkg::*;

  cfg_t      regs;
  logic      restart;
  logic      room;
  logic      busy;
  res_push_t push;

  hlcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .regs    (regs),
    .restart (restart)
  );

  // byte parser: holds the accepted byte and all frame state
  hlcd_parser #(
    .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .cfg     (regs),
    .restart (restart),
    .room    (room),
    .busy    (busy),
    .push    (push)
  );

  // output register plus skid entry, so stream.ready never waits on result.ready
  hlcd_out_skid u_out (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .result (result)
  );

  // a filled skid entry implies the output register holds an item
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    !room |-> result.valid)
    else $error("skid entry full while result register empty");

  // a held byte with no room for its result must block the stream
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (busy && !room) |-> !stream.ready)
    else $error("stream accepted with a byte stuck in the input register");

  // frame-end items carry the last mark and no data byte
  a_frame_end_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.result_kind == RESULT_FRAME_END)) |->
      (result.frame_last && (result.out_byte == 8'd0)))
    else $error("malformed frame-end item");

  // a result is pushed only when the skid can take it
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> room)
    else $error("result pushed while skid entry full");

endmodule
